// ===== rtl/lifetime_aliasing_block_allocator_assert.svh =====
// Assertion helpers for the allocator checker.
`ifndef LIFETIME_ALIASING_BLOCK_ALLOCATOR_ASSERT_SVH
`define LIFETIME_ALIASING_BLOCK_ALLOCATOR_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define LABA_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator check failed");

// Clocked assertion that also holds through reset.
`define LABA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");

`endif

// ===== rtl/laba_pkg.sv =====
package laba_pkg;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_SHARED    = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_RELEASED  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [7:0] USERS_MAX   = 8'd255;
  localparam logic [63:0] HEAP_RESET = 64'd268435456;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [4:0]  align_log2;
    logic [15:0] begin_pass;
    logic [15:0] end_pass;
    logic [31:0] release_offset;
    logic [31:0] release_size;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_offset;
    logic [31:0] result_size;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ARD, S_AEV, S_AFIT, S_SRD, S_SWR,
    S_WPAD, S_WUSE, S_WREM, S_MRD, S_MEV, S_MEND, S_DONE
  } state_t;

endpackage

// ===== rtl/lifetime_aliasing_block_allocator.sv =====
// First-fit heap allocator with pass-lifetime sharing. The block table lives in one
// memory with a registered read, so each entry visited takes a read and an
// evaluate state. An allocate walks the entries and tries a fit on each free entry;
// on a split it shifts the later entries up and writes the used entry with any pad
// and remainder entries before the result. A release does the lookup and the
// free-block merge in one compacting walk. After reset and after each heap_size
// write, busy stays high for one cycle while the table is rebuilt. busy is high
// from the accepted start until the cycle after done; done marks each result for
// one cycle only, since the receiver cannot hold it off.
module lifetime_aliasing_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  laba_pkg::cmd_t cmd,
  output logic          done,
  output laba_pkg::rsp_t rsp,
  input  logic          heap_size_we,
  input  logic [31:0]   heap_size_wdata
);
  import laba_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int XW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 2 * AW + 24;
  localparam logic [CW:0] MAX_CNT = (CW + 1)'(MAX_BLOCKS);

  state_t state, state_next;
  logic [AW-1:0] heap_q;
  logic [CW-1:0] cnt, cnt_next, i_q, i_next, j_q, j_next, w_q, w_next;
  logic [1:0] d_q, d_next;
  cmd_t cmd_q;
  logic found, found_next;
  logic [AW-1:0] cur_off, cur_off_next;
  logic [AW-1:0] aligned_q, aligned_next;
  logic [XW-1:0] endq, endq_next, sum_q, sum_next;
  logic [EW-1:0] pend, pend_next;
  rsp_t res, res_next;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, rdata;

  logic [AW-1:0] e_off, e_size;
  logic [15:0] e_last;
  logic [7:0] e_users;
  logic [EW-1:0] e_mod;
  logic [XW-1:0] al, aligned_c;
  logic pad_nz, rem_nz, fit;
  logic [1:0] d_c;
  logic [XW-1:0] p_end;

  laba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );

  assign e_off   = rdata[EW-1 -: AW];
  assign e_size  = rdata[EW-AW-1 -: AW];
  assign e_last  = rdata[23:8];
  assign e_users = rdata[7:0];

  assign al        = XW'(1) << cmd_q.align_log2;
  assign aligned_c = (XW'(e_off) + al - XW'(1)) & ~(al - XW'(1));
  assign pad_nz    = aligned_q != cur_off;
  assign rem_nz    = sum_q != endq;
  assign fit       = sum_q <= endq;
  assign d_c       = {1'b0, pad_nz} + {1'b0, rem_nz};
  assign p_end     = XW'(pend[EW-1 -: AW]) + XW'(pend[EW-AW-1 -: AW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      heap_q <= AW'(HEAP_RESET);
      cnt    <= CW'(1);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (heap_size_we) begin
        heap_q <= AW'({32'd0, heap_size_wdata});
        state  <= S_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
    end
    i_q       <= i_next;
    j_q       <= j_next;
    w_q       <= w_next;
    d_q       <= d_next;
    found     <= found_next;
    cur_off   <= cur_off_next;
    aligned_q <= aligned_next;
    endq      <= endq_next;
    sum_q     <= sum_next;
    pend      <= pend_next;
    res       <= res_next;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    i_next       = i_q;
    j_next       = j_q;
    w_next       = w_q;
    d_next       = d_q;
    found_next   = found;
    cur_off_next = cur_off;
    aligned_next = aligned_q;
    endq_next    = endq;
    sum_next     = sum_q;
    pend_next    = pend;
    res_next     = res;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = i_q[IW-1:0];
    e_mod        = rdata;
    case (state)
      S_INIT: begin
        ram_we     = 1'b1;
        ram_wdata  = {{AW{1'b0}}, heap_q, 24'd0};
        cnt_next   = CW'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          i_next     = '0;
          w_next     = '0;
          found_next = 1'b0;
          res_next   = '{status: ST_NO_FIT, result_offset: '0, result_size: '0};
          if (cmd.opcode == OP_RELEASE) begin
            res_next.status = ST_NOT_FOUND;
            state_next      = S_MRD;
          end else if (cmd.request_size == 32'd0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_ARD;
          end
        end
      end
      S_ARD: begin
        state_next = S_AEV;
      end
      S_AEV: begin
        if (e_users != 8'd0) begin
          if (e_last <= cmd_q.begin_pass && XW'(e_size) >= XW'(cmd_q.request_size) &&
              e_users != USERS_MAX) begin
            ram_we    = 1'b1;
            ram_waddr = i_q[IW-1:0];
            ram_wdata = {e_off, e_size,
                         (cmd_q.end_pass > e_last) ? cmd_q.end_pass : e_last,
                         e_users + 8'd1};
            res_next  = '{status: ST_SHARED, result_offset: 32'(e_off),
                          result_size: 32'(e_size)};
            state_next = S_DONE;
          end else begin
            i_next     = i_q + CW'(1);
            state_next = (i_q + CW'(1) == cnt) ? S_DONE : S_ARD;
          end
        end else begin
          cur_off_next = e_off;
          aligned_next = AW'(aligned_c);
          endq_next    = XW'(e_off) + XW'(e_size);
          sum_next     = aligned_c + XW'(cmd_q.request_size);
          state_next   = S_AFIT;
        end
      end
      S_AFIT: begin
        if (fit && aligned_q == AW'(sum_q - XW'(cmd_q.request_size)) &&
            ({1'b0, cnt} + (CW + 1)'(d_c)) <= MAX_CNT) begin
          d_next = d_c;
          j_next = cnt - CW'(1);
          w_next = i_q;
          state_next = (d_c != 2'd0 && i_q + CW'(1) < cnt) ? S_SRD : S_WPAD;
        end else begin
          i_next     = i_q + CW'(1);
          state_next = (i_q + CW'(1) == cnt) ? S_DONE : S_ARD;
        end
      end
      S_SRD: begin
        ram_raddr  = j_q[IW-1:0];
        state_next = S_SWR;
      end
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(j_q + CW'(d_q));
        ram_wdata = rdata;
        j_next    = j_q - CW'(1);
        state_next = (j_q == i_q + CW'(1)) ? S_WPAD : S_SRD;
      end
      S_WPAD: begin
        if (pad_nz) begin
          ram_we    = 1'b1;
          ram_waddr = w_q[IW-1:0];
          ram_wdata = {cur_off, aligned_q - cur_off, 24'd0};
          w_next    = w_q + CW'(1);
        end
        state_next = S_WUSE;
      end
      S_WUSE: begin
        ram_we     = 1'b1;
        ram_waddr  = w_q[IW-1:0];
        ram_wdata  = {aligned_q, AW'(cmd_q.request_size), cmd_q.end_pass, 8'd1};
        w_next     = w_q + CW'(1);
        state_next = S_WREM;
      end
      S_WREM: begin
        if (rem_nz) begin
          ram_we    = 1'b1;
          ram_waddr = w_q[IW-1:0];
          ram_wdata = {AW'(sum_q), AW'(endq - sum_q), 24'd0};
        end
        cnt_next   = cnt + CW'(d_q);
        res_next   = '{status: ST_NEW, result_offset: 32'(aligned_q),
                       result_size: cmd_q.request_size};
        state_next = S_DONE;
      end
      S_MRD: begin
        state_next = S_MEV;
      end
      S_MEV: begin
        if (!found && XW'(e_off) == XW'(cmd_q.release_offset) &&
            XW'(e_size) == XW'(cmd_q.release_size)) begin
          found_next = 1'b1;
          if (e_users != 8'd0) begin
            e_mod[7:0] = e_users - 8'd1;
            if (e_users == 8'd1) begin
              e_mod[23:8] = 16'd0;
            end
            res_next = '{status: ST_RELEASED, result_offset: 32'(e_off),
                         result_size: 32'(e_size)};
          end
        end
        if (i_q == '0) begin
          pend_next = e_mod;
        end else if (pend[7:0] == 8'd0 && e_mod[7:0] == 8'd0 && p_end == XW'(e_off)) begin
          pend_next[EW-AW-1 -: AW] = pend[EW-AW-1 -: AW] + e_size;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = w_q[IW-1:0];
          ram_wdata = pend;
          w_next    = w_q + CW'(1);
          pend_next = e_mod;
        end
        i_next     = i_q + CW'(1);
        state_next = (i_q + CW'(1) == cnt) ? S_MEND : S_MRD;
      end
      S_MEND: begin
        ram_we     = 1'b1;
        ram_waddr  = w_q[IW-1:0];
        ram_wdata  = pend;
        cnt_next   = w_q + CW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;
  assign rsp  = res;

endmodule

// ===== rtl/laba_ram.sv =====
module laba_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/laba_checker.sv =====
`include "lifetime_aliasing_block_allocator_assert.svh"

module laba_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input laba_pkg::rsp_t rsp
);
  import laba_pkg::*;

  `LABA_ASSERT(a_take_goes_busy, start && !busy |=> busy)
  `LABA_ASSERT(a_done_while_busy, done |-> busy)
  `LABA_ASSERT(a_done_then_idle, done |=> !busy && !done)
  `LABA_ASSERT(a_status_legal, done |-> rsp.status <= ST_NOT_FOUND)
  `LABA_ASSERT(a_miss_zero, done && (rsp.status == ST_NO_FIT || rsp.status == ST_NOT_FOUND) |-> rsp.result_offset == 32'd0 && rsp.result_size == 32'd0)

endmodule

bind lifetime_aliasing_block_allocator laba_checker u_laba_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// ===== tb/sv/lifetime_aliasing_block_allocator_test.sv =====
`timescale 1ns / 1ps

module lifetime_aliasing_block_allocator_test;
  import laba_pkg::*;

  localparam int NBLK = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  rsp_t rsp;
  logic heap_size_we = 1'b0;
  logic [31:0] heap_size_wdata = '0;

  lifetime_aliasing_block_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .heap_size_we(heap_size_we),
    .heap_size_wdata(heap_size_wdata)
  );

  always #5 clk = ~clk;

  // heap model
  logic [31:0] heap_bytes;
  logic [31:0] blk_off [NBLK];
  logic [31:0] blk_size [NBLK];
  logic [15:0] blk_last [NBLK];
  logic [7:0]  blk_users [NBLK];
  int          blk_count;

  cmd_t pending_cmds[$];
  cmd_t issued_cmds[$];
  rsp_t expected_rsps[$];
  rsp_t live_blocks[$];
  int   errors = 0;
  int   transfers = 0;
  longint cycles = 0;
  bit   quiet_sender = 1'b0;
  int   n_new = 0, n_shared = 0, n_nofit = 0, n_rel = 0, n_nf = 0;

  function automatic void clear_heap(logic [31:0] sz);
    heap_bytes = sz;
    for (int k = 0; k < NBLK; k++) begin
      blk_off[k] = '0; blk_size[k] = '0; blk_last[k] = '0; blk_users[k] = '0;
    end
    blk_size[0] = sz;
    blk_count = 1;
  endfunction

  function automatic void shift_up(int dst, int src);
    int n;
    n = blk_count - src;
    for (int k = n - 1; k >= 0; k--) begin
      blk_off[dst+k] = blk_off[src+k]; blk_size[dst+k] = blk_size[src+k];
      blk_last[dst+k] = blk_last[src+k]; blk_users[dst+k] = blk_users[src+k];
    end
  endfunction

  function automatic void shift_down(int dst, int src);
    int n;
    n = blk_count - src;
    for (int k = 0; k < n; k++) begin
      blk_off[dst+k] = blk_off[src+k]; blk_size[dst+k] = blk_size[src+k];
      blk_last[dst+k] = blk_last[src+k]; blk_users[dst+k] = blk_users[src+k];
    end
  endfunction

  function automatic void coalesce_free();
    int i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (blk_users[i] == 0 && blk_users[i+1] == 0 &&
          {32'd0, blk_off[i]} + {32'd0, blk_size[i]} == {32'd0, blk_off[i+1]}) begin
        blk_size[i] = blk_size[i] + blk_size[i+1];
        if (i + 2 < blk_count) shift_down(i + 1, i + 2);
        blk_count--;
        blk_off[blk_count] = '0; blk_size[blk_count] = '0;
        blk_last[blk_count] = '0; blk_users[blk_count] = '0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic rsp_t place_block(cmd_t c);
    rsp_t r;
    logic [63:0] al, off, aligned, pad, need, rem, req;
    int add, k;
    r = '{status: ST_NO_FIT, result_offset: '0, result_size: '0};
    req = {32'd0, c.request_size};
    if (req == 0) return r;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_users[i] > 0) begin
        if (blk_last[i] <= c.begin_pass && {32'd0, blk_size[i]} >= req &&
            blk_users[i] < USERS_MAX) begin
          blk_users[i]++;
          if (c.end_pass > blk_last[i]) blk_last[i] = c.end_pass;
          r = '{status: ST_SHARED, result_offset: blk_off[i], result_size: blk_size[i]};
          return r;
        end
        continue;
      end
      al = 64'd1 << c.align_log2;
      off = {32'd0, blk_off[i]};
      aligned = (off + al - 1) & ~(al - 1);
      pad = aligned - off;
      need = pad + req;
      if (need > {32'd0, blk_size[i]}) continue;
      rem = {32'd0, blk_size[i]} - need;
      add = 1 + (pad > 0) + (rem > 0);
      if (blk_count - 1 + add > NBLK) continue;
      if (add > 1 && i + 1 < blk_count) shift_up(i + add, i + 1);
      k = i;
      if (pad > 0) begin
        blk_off[k] = off[31:0]; blk_size[k] = pad[31:0]; blk_last[k] = '0; blk_users[k] = '0;
        k++;
      end
      blk_off[k] = aligned[31:0]; blk_size[k] = req[31:0];
      blk_last[k] = c.end_pass; blk_users[k] = 8'd1;
      k++;
      if (rem > 0) begin
        blk_off[k] = aligned[31:0] + req[31:0]; blk_size[k] = rem[31:0];
        blk_last[k] = '0; blk_users[k] = '0;
      end
      blk_count += add - 1;
      r = '{status: ST_NEW, result_offset: aligned[31:0], result_size: req[31:0]};
      return r;
    end
    return r;
  endfunction

  function automatic rsp_t drop_block(cmd_t c);
    rsp_t r;
    r = '{status: ST_NOT_FOUND, result_offset: '0, result_size: '0};
    for (int i = 0; i < blk_count; i++) begin
      if (blk_off[i] != c.release_offset || blk_size[i] != c.release_size) continue;
      if (blk_users[i] > 0) begin
        blk_users[i]--;
        if (blk_users[i] == 0) blk_last[i] = '0;
        r = '{status: ST_RELEASED, result_offset: blk_off[i], result_size: blk_size[i]};
      end
      break;
    end
    coalesce_free();
    return r;
  endfunction

  function automatic rsp_t predict_heap(cmd_t c);
    if (c.opcode == OP_ALLOC) return place_block(c);
    return drop_block(c);
  endfunction

  function automatic cmd_t alloc_cmd(logic [31:0] sz, logic [4:0] lg,
                                     logic [15:0] b, logic [15:0] e);
    cmd_t c;
    c = '0;
    c.opcode = OP_ALLOC; c.request_size = sz; c.align_log2 = lg;
    c.begin_pass = b; c.end_pass = e;
    c.release_offset = $urandom; c.release_size = $urandom;
    return c;
  endfunction

  function automatic cmd_t release_cmd(logic [31:0] off, logic [31:0] sz);
    cmd_t c;
    c = '0;
    c.opcode = OP_RELEASE; c.release_offset = off; c.release_size = sz;
    c.request_size = $urandom; c.align_log2 = 5'($urandom);
    c.begin_pass = 16'($urandom);
    c.end_pass = 16'($urandom);
    return c;
  endfunction

  // driver: predict when the transfer happens
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rsps.insert(expected_rsps.size(), predict_heap(cmd));
        issued_cmds.insert(issued_cmds.size(), cmd);
        transfers++;
      end
      if (start && busy) begin
        // hold
      end else if (pending_cmds.size() > 0 && (quiet_sender || $urandom_range(99) >= 6)) begin
        cmd <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("result with nothing expected: status %0d", rsp.status);
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        void'(issued_cmds.pop_front());
        if (rsp.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp.status); errors++;
        end
        if (rsp.result_offset !== exp_r.result_offset) begin
          $error("result_offset: expected %0h, got %0h", exp_r.result_offset,
                 rsp.result_offset);
          errors++;
        end
        if (rsp.result_size !== exp_r.result_size) begin
          $error("result_size: expected %0h, got %0h", exp_r.result_size, rsp.result_size);
          errors++;
        end
        case (exp_r.status)
          ST_NEW: n_new++;
          ST_SHARED: n_shared++;
          ST_NO_FIT: n_nofit++;
          ST_RELEASED: n_rel++;
          default: n_nf++;
        endcase
        if (exp_r.status == ST_NEW || exp_r.status == ST_SHARED)
          live_blocks.insert(live_blocks.size(), exp_r);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lifetime_aliasing_block_allocator test failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0 || busy)
      @(posedge clk);
    repeat (4 * NBLK + 20) @(posedge clk);
  endtask

  task automatic write_heap(logic [31:0] sz);
    heap_size_we <= 1'b1;
    heap_size_wdata <= sz;
    @(posedge clk);
    heap_size_we <= 1'b0;
    clear_heap(sz);
    live_blocks.delete();
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // fire a release of something allocated earlier, mostly correct
  function automatic cmd_t random_release();
    rsp_t b;
    int idx;
    if (live_blocks.size() > 0 && $urandom_range(9) < 8) begin
      idx = $urandom_range(live_blocks.size() - 1);
      b = live_blocks[idx];
      live_blocks.delete(idx);
      return release_cmd(b.result_offset, b.result_size);
    end
    return release_cmd($urandom, $urandom);
  endfunction

  task automatic random_phase(int n, logic [31:0] hsz);
    cmd_t c;
    logic [31:0] sz;
    for (int j = 0; j < n; j++) begin
      while (pending_cmds.size() > 4) @(posedge clk);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          sz = (hsz < 64) ? $urandom_range(1, 8) : $urandom_range(1, hsz / 48 + 1);
          c = alloc_cmd(sz, 5'($urandom_range(0, 8)), 16'($urandom_range(0, 40)),
                        16'($urandom_range(0, 40)));
        end
        4: c = alloc_cmd($urandom, 5'($urandom), 16'($urandom), 16'($urandom));
        default: c = random_release();
      endcase
      pending_cmds.insert(pending_cmds.size(), c);
    end
    drain();
  endtask

  initial begin
    cmd_t c;
    clear_heap(HEAP_RESET[31:0]);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd0, 5'd0, 16'd0, 16'd0));
    pending_cmds.insert(pending_cmds.size(),
                        alloc_cmd(32'hFFFF_FFFF, 5'd31, 16'hFFFF, 16'hFFFF));
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd100, 5'd0, 16'd0, 16'd5));
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd64, 5'd31, 16'd0, 16'd5));
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd64, 5'd12, 16'd0, 16'd3));
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd50, 5'd0, 16'd5, 16'd9));
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd50, 5'd0, 16'd2, 16'd9));
    pending_cmds.insert(pending_cmds.size(), release_cmd(32'd0, 32'd100));
    pending_cmds.insert(pending_cmds.size(), release_cmd(32'd0, 32'd100));
    pending_cmds.insert(pending_cmds.size(), release_cmd(32'd0, 32'd100));
    pending_cmds.insert(pending_cmds.size(), release_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.insert(pending_cmds.size(), release_cmd(32'd4096, 32'd64));
    drain();

    // user count saturation on a single-block heap
    write_heap(32'd16);
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd16, 5'd0, 16'd0, 16'd0));
    for (int j = 0; j < 256; j++)
      pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd4, 5'd0, 16'd0, 16'd0));
    drain();

    // table full: many small blocks with padding
    write_heap(32'd4096);
    for (int j = 0; j < 70; j++)
      pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd1, 5'd3, 16'd100, 16'd200));
    drain();

    write_heap(32'd0);
    pending_cmds.insert(pending_cmds.size(), alloc_cmd(32'd1, 5'd0, 16'd0, 16'd0));
    pending_cmds.insert(pending_cmds.size(), release_cmd(32'd0, 32'd0));
    drain();

    write_heap(32'hFFFF_FFFF);
    quiet_sender = 1'b1;
    random_phase(200, 32'hFFFF_FFFF);
    quiet_sender = 1'b0;
    write_heap(32'd1);
    random_phase(100, 32'd1);
    write_heap(32'd3000);
    random_phase(400, 32'd3000);
    write_heap(32'd200);
    random_phase(300, 32'd200);

    drain();
    $display("ran %0d transfers: %0d new, %0d shared, %0d no fit, %0d released, %0d not found",
             transfers, n_new, n_shared, n_nofit, n_rel, n_nf);
    $display("heap sizes covered: 0, 1, 16, 200, 3000, 4096, 2^28, 2^32-1");
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("lifetime_aliasing_block_allocator test passed");
    end else begin
      $display("lifetime_aliasing_block_allocator test failed");
    end
    $finish;
  end

endmodule
